>>> sv/assert_macros.svh
// assertion macros used by the checker file km_checker.sv
// no dependencies; clock i_clk and active-low reset i_rst_n are assumed
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent in the cycle after the antecedent
`define KM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequent in the same cycle as the antecedent
`define KM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/km_pkg.sv
// shared types and codes for the k-means clustering block
// no dependencies
package km_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_POINT  = 2'd0,
        CMD_LOAD_CENTRE = 2'd1,
        CMD_RUN         = 2'd2,
        CMD_READ        = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_POINT_COUNT   = 3'd0,
        REG_DIM_COUNT     = 3'd1,
        REG_CLUSTER_COUNT = 3'd2,
        REG_MAX_ITER      = 3'd3,
        REG_CONV_THRESH   = 3'd4
    } t_reg;

    localparam int CFG_W = 16;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] value;
        logic [13:0]        element_index;
    } t_req;

    typedef struct packed {
        logic       kind;
        logic [3:0] cluster;
        logic [9:0] iterations;
        logic       converged;
    } t_res;

endpackage

>>> sv/km_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module km_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/km_div.sv
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module km_div #(
    parameter int N_W = 26,
    parameter int D_W = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);
    localparam int C_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic           r_busy;
    logic [C_W-1:0] r_cnt;
    logic [D_W:0]   r_rem;
    logic [N_W-1:0] r_quo;
    logic [D_W-1:0] r_den;
    logic [D_W:0]   w_shift;
    logic           w_fit;

    assign w_shift = {r_rem[D_W-1:0], r_quo[N_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_den};
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(N_W - 1);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_fit ? (w_shift - {1'b0, r_den}) : w_shift;
                r_quo <= {r_quo[N_W-2:0], w_fit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule

>>> sv/kmeans_lloyd_clustering_top.sv
// Lloyd k-means clustering engine: while idle, loads and reads take one request
// per cycle (a read answers on the cycle after it is taken; loads answer nothing).
// A run holds busy high for a clearing pass over all MAX_POINTS assignments,
// then each pass clears MAX_CLUSTERS*MAX_DIMS sums, does the distance work on
// the shared multiplier, accumulates each point into its cluster's sums and
// divides each centre element of a non-empty cluster in the serial divider.
// After reset busy is high while all MAX_POINTS assignments are cleared.
// The run report is a single-cycle strobe; the receiver cannot stall.
// depends on km_pkg, km_ram, km_div
module kmeans_lloyd_clustering_top import km_pkg::*; #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_DIMS     = 16,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_valid,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
    localparam int CW     = COORD_WIDTH;
    localparam int PE     = MAX_POINTS * MAX_DIMS;
    localparam int CE     = MAX_CLUSTERS * MAX_DIMS;
    localparam int PA_W   = (PE > 1) ? $clog2(PE) : 1;
    localparam int CA_W   = (CE > 1) ? $clog2(CE) : 1;
    localparam int PI_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int KI_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PC_W   = $clog2(MAX_POINTS + 1);
    localparam int KC_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int DC_W   = $clog2(MAX_DIMS + 1);
    localparam int SUM_W  = CW + $clog2(MAX_POINTS) + 1;
    localparam int SQ_W   = 2 * CW + 2;
    localparam int DIST_W = SQ_W + $clog2(MAX_DIMS + 1);
    localparam int CHG_W  = CW + 2 + $clog2(CE + 1);
    localparam int CMAX   = (MAX_POINTS > CE) ? MAX_POINTS : CE;
    localparam int CNT_W  = $clog2(CMAX + 1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_PSTART, S_SCLR, S_ARD, S_ASQ, S_AADD, S_ASG,
        S_URD, S_UWR, S_MCHK, S_MRD, S_MDIV, S_MWAIT, S_MWR, S_PEND, S_RPT
    } t_state;

    t_state r_state;

    // configuration
    logic [PC_W-1:0] r_pcnt;
    logic [DC_W-1:0] r_dcnt;
    logic [KC_W-1:0] r_kcnt;
    logic [9:0]      r_maxit;
    logic [15:0]     r_thr;

    // run state
    logic                    r_rep;
    logic [9:0]              r_iter;
    logic                    r_conv;
    logic [CNT_W-1:0]        r_cnt;
    logic [PI_W-1:0]         r_p;
    logic [KI_W-1:0]         r_k;
    logic [DI_W-1:0]         r_d;
    logic [KI_W-1:0]         r_bestk;
    logic [DIST_W-1:0]       r_dist;
    logic [DIST_W-1:0]       r_best;
    logic [SQ_W-1:0]         r_sq;
    logic [PC_W-1:0]         r_size [MAX_CLUSTERS];
    logic signed [CW-1:0]    r_old;
    logic                    r_neg;
    logic signed [CHG_W-1:0] r_chg;
    logic                    r_div_go;
    logic                    r_rd_pend;
    logic                    r_rd_oor;
    logic                    r_rpt;

    // rams
    logic                    w_pt_we;
    logic [PA_W-1:0]         w_pt_raddr;
    logic signed [CW-1:0]    w_pt_rdata;
    logic                    w_ce_we;
    logic [CA_W-1:0]         w_ce_waddr;
    logic [CW-1:0]           w_ce_wdata;
    logic [CA_W-1:0]         w_ce_raddr;
    logic signed [CW-1:0]    w_ce_rdata;
    logic                    w_sm_we;
    logic [CA_W-1:0]         w_sm_waddr;
    logic [SUM_W-1:0]        w_sm_wdata;
    logic [CA_W-1:0]         w_sm_raddr;
    logic signed [SUM_W-1:0] w_sm_rdata;
    logic                    w_as_we;
    logic [PI_W-1:0]         w_as_waddr;
    logic [KI_W-1:0]         w_as_wdata;
    logic [KI_W-1:0]         w_as_rdata;

    logic                    w_accept;
    logic signed [CW-1:0]    w_val;
    logic [31:0]             w_idx;
    logic [CA_W-1:0]         w_kaddr;
    logic [CA_W-1:0]         w_baddr;
    logic signed [CW:0]      w_diff;
    logic [DIST_W-1:0]       n_dist;
    logic                    w_dlast;
    logic                    w_klast;
    logic                    w_plast;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_quo;
    logic [SUM_W-1:0]        w_num;
    logic signed [CW-1:0]    w_mean;
    logic signed [CHG_W-1:0] n_chg;
    logic [CHG_W-1:0]        w_mag;
    logic [31:0]             w_clu;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_val    = CW'(i_req.value);
    assign w_idx    = 32'(i_req.element_index);
    assign w_kaddr  = CA_W'(r_k * MAX_DIMS + r_d);
    assign w_baddr  = CA_W'(r_bestk * MAX_DIMS + r_d);
    assign w_dlast  = (DC_W'(r_d) == r_dcnt - DC_W'(1));
    assign w_klast  = (KC_W'(r_k) == r_kcnt - KC_W'(1));
    assign w_plast  = (PC_W'(r_p) == r_pcnt - PC_W'(1));

    // memory port steering
    assign w_pt_we    = w_accept && (i_req.cmd == CMD_LOAD_POINT) && (w_idx < PE);
    assign w_pt_raddr = PA_W'(r_p * MAX_DIMS + r_d);

    always_comb begin
        w_ce_we    = 1'b0;
        w_ce_waddr = w_kaddr;
        w_ce_wdata = w_mean;
        if (r_state == S_MWR) begin
            w_ce_we = 1'b1;
        end else if (w_accept && (i_req.cmd == CMD_LOAD_CENTRE) && (w_idx < CE)) begin
            w_ce_we    = 1'b1;
            w_ce_waddr = CA_W'(w_idx);
            w_ce_wdata = w_val;
        end
    end
    assign w_ce_raddr = w_kaddr;

    assign w_sm_we    = (r_state == S_SCLR) || (r_state == S_UWR);
    assign w_sm_waddr = (r_state == S_SCLR) ? CA_W'(r_cnt) : w_baddr;
    assign w_sm_wdata = (r_state == S_SCLR) ? '0 : (w_sm_rdata + SUM_W'(w_pt_rdata));
    assign w_sm_raddr = (r_state == S_URD) ? w_baddr : w_kaddr;

    assign w_as_we    = (r_state == S_CLR) || (r_state == S_ASG);
    assign w_as_waddr = (r_state == S_CLR) ? PI_W'(r_cnt) : r_p;
    assign w_as_wdata = (r_state == S_CLR) ? '0 : r_bestk;

    km_ram #(.WIDTH(CW), .DEPTH(PE)) u_pt_ram (
        .i_clk, .i_we(w_pt_we), .i_waddr(PA_W'(w_idx)), .i_wdata(w_val),
        .i_raddr(w_pt_raddr), .o_rdata(w_pt_rdata)
    );
    km_ram #(.WIDTH(CW), .DEPTH(CE)) u_ce_ram (
        .i_clk, .i_we(w_ce_we), .i_waddr(w_ce_waddr), .i_wdata(w_ce_wdata),
        .i_raddr(w_ce_raddr), .o_rdata(w_ce_rdata)
    );
    km_ram #(.WIDTH(SUM_W), .DEPTH(CE)) u_sum_ram (
        .i_clk, .i_we(w_sm_we), .i_waddr(w_sm_waddr), .i_wdata(w_sm_wdata),
        .i_raddr(w_sm_raddr), .o_rdata(w_sm_rdata)
    );
    km_ram #(.WIDTH(KI_W), .DEPTH(MAX_POINTS)) u_asg_ram (
        .i_clk, .i_we(w_as_we), .i_waddr(w_as_waddr), .i_wdata(w_as_wdata),
        .i_raddr(PI_W'(w_idx)), .o_rdata(w_as_rdata)
    );

    // mean of a cluster element: magnitude through the serial divider
    assign w_num = (w_sm_rdata < 0) ? SUM_W'(-w_sm_rdata) : SUM_W'(w_sm_rdata);
    km_div #(.N_W(SUM_W), .D_W(PC_W)) u_div (
        .i_clk, .i_rst_n, .i_start(r_div_go), .i_num(w_num), .i_den(r_size[r_k]),
        .o_done(w_div_done), .o_quo(w_quo)
    );
    assign w_mean = r_neg ? CW'(-w_quo) : CW'(w_quo);
    assign n_chg  = r_chg + CHG_W'(r_old) - CHG_W'(w_mean);
    assign w_mag  = (r_chg < 0) ? CHG_W'(-r_chg) : CHG_W'(r_chg);

    assign w_diff = (CW+1)'(w_pt_rdata) - (CW+1)'(w_ce_rdata);
    assign n_dist = r_dist + DIST_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_rep     <= 1'b0;
            r_cnt     <= '0;
            r_iter    <= '0;
            r_conv    <= 1'b0;
            r_pcnt    <= PC_W'(1);
            r_dcnt    <= DC_W'(1);
            r_kcnt    <= KC_W'(1);
            r_maxit   <= 10'd100;
            r_thr     <= 16'd1;
            r_div_go  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rpt     <= 1'b0;
        end else begin
            r_div_go  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rpt     <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_POINT_COUNT: begin
                        if (i_cfg_data[10:0] == '0) r_pcnt <= PC_W'(1);
                        else if (32'(i_cfg_data[10:0]) > MAX_POINTS) r_pcnt <= PC_W'(MAX_POINTS);
                        else r_pcnt <= PC_W'(i_cfg_data[10:0]);
                    end
                    REG_DIM_COUNT: begin
                        if (i_cfg_data[4:0] == '0) r_dcnt <= DC_W'(1);
                        else if (32'(i_cfg_data[4:0]) > MAX_DIMS) r_dcnt <= DC_W'(MAX_DIMS);
                        else r_dcnt <= DC_W'(i_cfg_data[4:0]);
                    end
                    REG_CLUSTER_COUNT: begin
                        if (i_cfg_data[4:0] == '0) r_kcnt <= KC_W'(1);
                        else if (32'(i_cfg_data[4:0]) > MAX_CLUSTERS)
                            r_kcnt <= KC_W'(MAX_CLUSTERS);
                        else r_kcnt <= KC_W'(i_cfg_data[4:0]);
                    end
                    REG_MAX_ITER:    r_maxit <= i_cfg_data[9:0];
                    REG_CONV_THRESH: r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLR: begin
                    if (32'(r_cnt) == MAX_POINTS - 1) begin
                        r_state <= r_rep ? S_PSTART : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept && i_req.cmd == CMD_RUN) begin
                        r_state <= S_CLR;
                        r_rep   <= 1'b1;
                        r_cnt   <= '0;
                        r_iter  <= '0;
                        r_conv  <= 1'b0;
                    end else if (w_accept && i_req.cmd == CMD_READ) begin
                        r_rd_pend <= 1'b1;
                        r_rd_oor  <= !(w_idx < MAX_POINTS);
                    end
                end
                S_PSTART: begin
                    r_cnt   <= '0;
                    r_state <= (r_maxit == '0) ? S_RPT : S_SCLR;
                end
                S_SCLR: begin
                    for (int i = 0; i < MAX_CLUSTERS; i++) r_size[i] <= '0;
                    if (32'(r_cnt) == CE - 1) begin
                        r_p     <= '0;
                        r_k     <= '0;
                        r_d     <= '0;
                        r_dist  <= '0;
                        r_state <= S_ARD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ARD: r_state <= S_ASQ;
                S_ASQ: begin
                    r_sq    <= SQ_W'(w_diff * w_diff);
                    r_state <= S_AADD;
                end
                S_AADD: begin
                    if (w_dlast) begin
                        // ties keep the lower cluster
                        if (r_k == '0 || n_dist < r_best) begin
                            r_best  <= n_dist;
                            r_bestk <= r_k;
                        end
                        r_d    <= '0;
                        r_dist <= '0;
                        if (w_klast) begin
                            r_state <= S_ASG;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ARD;
                        end
                    end else begin
                        r_dist  <= n_dist;
                        r_d     <= r_d + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_ASG: begin
                    r_size[r_bestk] <= r_size[r_bestk] + 1'b1;
                    r_d             <= '0;
                    r_state         <= S_URD;
                end
                S_URD: r_state <= S_UWR;
                S_UWR: begin
                    if (w_dlast) begin
                        r_d <= '0;
                        r_k <= '0;
                        if (w_plast) begin
                            r_chg   <= '0;
                            r_state <= S_MCHK;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_dist  <= '0;
                            r_state <= S_ARD;
                        end
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_MCHK: begin
                    r_d <= '0;
                    // empty cluster keeps its centre
                    if (r_size[r_k] != '0) begin
                        r_state <= S_MRD;
                    end else if (w_klast) begin
                        r_state <= S_PEND;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MRD: r_state <= S_MDIV;
                S_MDIV: begin
                    r_old    <= w_ce_rdata;
                    r_neg    <= w_sm_rdata < 0;
                    r_div_go <= 1'b1;
                    r_state  <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_div_done) r_state <= S_MWR;
                end
                S_MWR: begin
                    r_chg <= n_chg;
                    if (w_dlast) begin
                        if (w_klast) begin
                            r_state <= S_PEND;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MCHK;
                        end
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_MRD;
                    end
                end
                S_PEND: begin
                    r_iter <= r_iter + 1'b1;
                    r_cnt  <= '0;
                    if (64'(w_mag) < 64'(r_thr)) begin
                        r_conv  <= 1'b1;
                        r_state <= S_RPT;
                    end else if (r_iter + 1'b1 < r_maxit) begin
                        r_state <= S_SCLR;
                    end else begin
                        r_state <= S_RPT;
                    end
                end
                S_RPT: begin
                    r_rpt   <= 1'b1;
                    r_rep   <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_clu = r_rd_oor ? 32'd0 : 32'(w_as_rdata);
    assign o_valid = r_rpt || r_rd_pend;

    always_comb begin
        o_res.iterations = r_iter;
        o_res.converged  = r_conv;
        if (r_rd_pend) begin
            o_res.kind    = KIND_READ;
            o_res.cluster = w_clu[3:0];
        end else begin
            o_res.kind    = KIND_REPORT;
            o_res.cluster = 4'd0;
        end
    end
endmodule

>>> sv/km_checker.sv
// port-level checks for the k-means top level, bound to every instance
// depends on km_pkg and assert_macros.svh
`include "assert_macros.svh"
module km_checker import km_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_valid,
    input t_res o_res
);
    logic w_acc;
    logic w_run_acc;
    logic w_rd_acc;
    logic w_ld_acc;
    logic w_rpt;
    assign w_acc     = start && !busy;
    assign w_run_acc = w_acc && (i_req.cmd == CMD_RUN);
    assign w_rd_acc  = w_acc && (i_req.cmd == CMD_READ);
    assign w_ld_acc  = w_acc && (i_req.cmd == CMD_LOAD_POINT || i_req.cmd == CMD_LOAD_CENTRE);
    assign w_rpt     = o_valid && (o_res.kind == KIND_REPORT);

    `KM_ASSERT_NEXT(a_run_busy, w_run_acc, busy)
    `KM_ASSERT_NEXT(a_read_answer, w_rd_acc, o_valid && o_res.kind == KIND_READ)
    `KM_ASSERT_NEXT(a_load_quiet, w_ld_acc, !o_valid)
    // a read taken in the report cycle may answer right after it
    `KM_ASSERT_NEXT(a_report_pulse, w_rpt, !w_rpt)
    `KM_ASSERT_NOW(a_report_zero, w_rpt, o_res.cluster == 4'd0)
endmodule

bind kmeans_lloyd_clustering_top km_checker u_km_checker (
    .i_clk, .i_rst_n, .start, .busy, .i_req, .o_valid, .o_res
);
